@@ hdl/gsoe_pkg.sv @@
// Shared types, constants and helpers for the synthetic oblique/embolden glyph stage.
package gsoe_pkg;

    localparam int MAX_DIM_DEF = 4095;
    localparam int MAX_PX_DEF  = 255;

    localparam int DIM_W   = 12;
    localparam int COL_W   = 13;
    localparam int PIX_W   = 8;
    localparam int PX_W    = 8;
    localparam int SLIDE_W = 10;

    // slant constant 0.21 as 14092861 / 2^26
    localparam int                SLANT_SHIFT = 26;
    localparam int                SLANT_W     = 24;
    localparam logic [SLANT_W-1:0] SLANT_NUM  = 24'd14092861;
    localparam int                PROD_W      = DIM_W + SLANT_W;

    localparam int Q_DEPTH = 4;

    localparam int REG_AW = 5;

    typedef enum logic [2:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_OBLIQUE  = 3'd2,
        REG_EMBOLDEN = 3'd3,
        REG_PX_SIZE  = 3'd4
    } t_reg_idx;

    // One classified source pixel on its way to the back end
    typedef struct packed {
        logic [PIX_W-1:0]   cov;
        logic [DIM_W-1:0]   row;
        logic [DIM_W-1:0]   col;
        logic               col0;
        logic               row_last;
        logic               glyph_last;
        logic [SLIDE_W-1:0] slide;
        logic [SLIDE_W-1:0] shear;
    } t_item;

    // floor(px / 14) for px <= 255 via reciprocal 293 / 2^12
    function automatic logic [4:0] div14(input logic [PX_W-1:0] px);
        logic [16:0] p;
        p = {9'd0, px} * 17'd293;
        return p[16:12];
    endfunction

endpackage

@@ hdl/gsoe_front.sv @@
// Front end: accepts pixels, tracks row/column position, computes slide and shear products.
module gsoe_front
    import gsoe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [PIX_W-1:0] i_coverage,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    input  logic             i_oblique,
    input  logic             i_q_full,
    output logic             o_item_valid,
    output t_item            o_item
);

    localparam logic [PROD_W:0] HALF = (PROD_W+1)'(1) << (SLANT_SHIFT - 1);
    localparam logic [PROD_W:0] ONES = ((PROD_W+1)'(1) << SLANT_SHIFT) - (PROD_W+1)'(1);

    logic [DIM_W-1:0] r_col, r_row;
    logic [DIM_W-1:0] n_col, n_row;
    logic [DIM_W-1:0] col_now, row_now, d_now;
    logic             stall, take, restart, last_col, last_row;

    // stage 1
    logic             r_v1;
    logic [PIX_W-1:0] r_cov1;
    logic [DIM_W-1:0] r_row1, r_col1, r_d1, r_h1;
    logic             r_col0_1, r_rlast1, r_glast1, r_obl1;

    // stage 2
    logic              r_v2;
    logic [PIX_W-1:0]  r_cov2;
    logic [DIM_W-1:0]  r_row2, r_col2;
    logic              r_col0_2, r_rlast2, r_glast2, r_obl2;
    logic [PROD_W-1:0] r_p_slide, r_p_shear;
    logic [PROD_W:0]   sum_slide, sum_shear;

    assign stall  = r_v2 && i_q_full;
    assign o_full = stall;
    assign take   = i_push && !stall && (i_width != '0) && (i_height != '0);

    // shrunk dimensions restart the glyph at the origin
    assign restart  = (r_col >= i_width) || (r_row >= i_height);
    assign col_now  = restart ? '0 : r_col;
    assign row_now  = restart ? '0 : r_row;
    assign last_col = (col_now == i_width - DIM_W'(1));
    assign last_row = (row_now == i_height - DIM_W'(1));
    assign d_now    = i_height - DIM_W'(1) - row_now;

    always_comb begin
        n_col = col_now + DIM_W'(1);
        n_row = row_now;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_now + DIM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (take) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (!stall) begin
                r_v1 <= take;
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_cov1    <= i_coverage;
            r_row1    <= row_now;
            r_col1    <= col_now;
            r_d1      <= d_now;
            r_h1      <= i_height;
            r_col0_1  <= (col_now == '0);
            r_rlast1  <= last_col;
            r_glast1  <= last_col && last_row;
            r_obl1    <= i_oblique;
            r_cov2    <= r_cov1;
            r_row2    <= r_row1;
            r_col2    <= r_col1;
            r_col0_2  <= r_col0_1;
            r_rlast2  <= r_rlast1;
            r_glast2  <= r_glast1;
            r_obl2    <= r_obl1;
            r_p_slide <= r_d1 * SLANT_NUM;
            r_p_shear <= r_h1 * SLANT_NUM;
        end
    end

    // slide rounds half up, shear rounds up
    assign sum_slide = {1'b0, r_p_slide} + HALF;
    assign sum_shear = {1'b0, r_p_shear} + ONES;

    assign o_item_valid = r_v2 && !i_q_full;

    always_comb begin
        o_item.cov        = r_cov2;
        o_item.row        = r_row2;
        o_item.col        = r_col2;
        o_item.col0       = r_col0_2;
        o_item.row_last   = r_rlast2;
        o_item.glyph_last = r_glast2;
        o_item.slide      = r_obl2 ? sum_slide[SLANT_SHIFT +: SLIDE_W] : '0;
        o_item.shear      = r_obl2 ? sum_shear[SLANT_SHIFT +: SLIDE_W] : '0;
    end

endmodule

@@ hdl/gsoe_queue.sv @@
// Short queue of classified pixels between the front and back ends.
module gsoe_queue
    import gsoe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_rd,
    output t_item o_item,
    output logic  o_empty
);

    localparam int AW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_item            r_mem [Q_DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == AW'(Q_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == AW'(Q_DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

@@ hdl/gsoe_back.sv @@
// Back end: dilation window, slide latch, tail sequencing and the result register.
module gsoe_back
    import gsoe_pkg::*;
#(
    parameter int MAX_PIXEL_SIZE = MAX_PX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  logic             i_q_empty,
    output logic             o_q_rd,
    input  logic [DIM_W-1:0] i_width,
    input  logic             i_embolden,
    input  logic [PX_W-1:0]  i_px_size,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [DIM_W-1:0] o_out_row,
    output logic [COL_W-1:0] o_out_column,
    output logic [PIX_W-1:0] o_out_value,
    output logic [COL_W-1:0] o_out_row_width,
    output logic             o_run_last,
    output logic             o_glyph_done
);

    localparam int WIN_DEPTH = MAX_PIXEL_SIZE / 14 + 1;
    localparam int EW        = $clog2(WIN_DEPTH);
    localparam int LEAVES    = 1 << $clog2(WIN_DEPTH);

    logic [PIX_W-1:0]   r_win [WIN_DEPTH];
    logic [SLIDE_W-1:0] r_slide;
    logic               r_act;
    logic [EW-1:0]      r_k;
    logic [DIM_W-1:0]   r_row;
    logic [COL_W-1:0]   r_base, r_bw;
    logic               r_rlast, r_glast;
    logic               r_ov;

    logic [EW-1:0]      q14, ext, nk, lim;
    logic [SLIDE_W-1:0] slide_now;
    logic               out_can, fire, gen_last, take;
    logic [PIX_W-1:0]   tree [1:2*LEAVES-1];

    assign q14 = EW'(div14(i_px_size));
    assign ext = !i_embolden ? '0 : ((q14 == '0) ? EW'(1) : q14);

    assign out_can  = !r_ov || i_pop;
    assign fire     = r_act && out_can;
    assign nk       = r_rlast ? ext : '0;
    assign gen_last = (r_k == nk);
    assign lim      = ext - r_k;
    assign take     = !i_q_empty && (!r_act || (fire && gen_last));
    assign o_q_rd   = take;
    assign o_empty  = !r_ov;

    assign slide_now = i_item.col0 ? i_item.slide : r_slide;

    // running max over the newest lim+1 pixels, as a balanced tree
    always_comb begin
        for (int i = 0; i < LEAVES; i++) begin
            tree[LEAVES + i] = '0;
            if (i < WIN_DEPTH && i <= int'(lim)) begin
                tree[LEAVES + i] = r_win[i];
            end
        end
        for (int j = LEAVES - 1; j >= 1; j--) begin
            tree[j] = (tree[2*j] > tree[2*j+1]) ? tree[2*j] : tree[2*j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_k   <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (take) begin
                r_act <= 1'b1;
                r_k   <= '0;
            end else if (fire && gen_last) begin
                r_act <= 1'b0;
            end else if (fire) begin
                r_k <= r_k + EW'(1);
            end
            if (fire) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            // a new row starts from a cleared window
            r_win[0] <= i_item.cov;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                r_win[i] <= i_item.col0 ? '0 : r_win[i-1];
            end
            r_slide <= slide_now;
            r_row   <= i_item.row;
            r_base  <= COL_W'(i_item.col) + COL_W'(slide_now);
            r_bw    <= COL_W'(i_width) + COL_W'(i_item.shear) + COL_W'(ext);
            r_rlast <= i_item.row_last;
            r_glast <= i_item.glyph_last;
        end
        if (fire) begin
            o_out_row       <= r_row;
            o_out_column    <= r_base + COL_W'(r_k);
            o_out_value     <= tree[1];
            o_out_row_width <= r_bw;
            o_run_last      <= gen_last;
            o_glyph_done    <= gen_last && r_glast;
        end
    end

endmodule

@@ hdl/glyph_synthetic_oblique_embolden.sv @@
// Top level of the synthetic oblique/embolden glyph stage: registers, front, queue, back.
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------------
//  input     push / full             i_coverage
//  result    empty / pop             o_out_row, o_out_column, o_out_value,
//                                    o_out_row_width, o_run_last, o_glyph_done
//  config    psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
//  One pixel per cycle while full is low; the last pixel of a row yields 1 + extra results
//  (extra up to MAX_PIXEL_SIZE/14) from the back end's tail sequencer, one result per cycle
//  while pop keeps up. A pixel passes front stages one and two, the queue, the back end's
//  window and the output register. Reset is synchronous; it empties the queue and result
//  register and restarts at row 0. A held result (pop low) stalls the back end; the front
//  keeps accepting until the four-entry queue is full and front stage two holds a pixel.
module glyph_synthetic_oblique_embolden
    import gsoe_pkg::*;
#(
    parameter int MAX_DIM        = MAX_DIM_DEF,
    parameter int MAX_PIXEL_SIZE = MAX_PX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [PIX_W-1:0]  i_coverage,
    output logic              empty,
    input  logic              pop,
    output logic [DIM_W-1:0]  o_out_row,
    output logic [COL_W-1:0]  o_out_column,
    output logic [PIX_W-1:0]  o_out_value,
    output logic [COL_W-1:0]  o_out_row_width,
    output logic              o_run_last,
    output logic              o_glyph_done,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [REG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [DIM_W-1:0] r_width, r_height;
    logic             r_oblique, r_embolden;
    logic [PX_W-1:0]  r_px_size;
    logic [DIM_W-1:0] w_sat, h_sat;
    logic [PX_W-1:0]  px_sat;
    logic             cfg_wr;
    logic [2:0]       reg_idx;

    t_item f_item, q_item;
    logic  f_valid, q_full, q_empty, q_rd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= DIM_W'(1);
            r_height   <= DIM_W'(1);
            r_oblique  <= 1'b0;
            r_embolden <= 1'b0;
            r_px_size  <= PX_W'(16);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WIDTH:    r_width    <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   r_height   <= pwdata[DIM_W-1:0];
                REG_OBLIQUE:  r_oblique  <= pwdata[0];
                REG_EMBOLDEN: r_embolden <= pwdata[0];
                REG_PX_SIZE:  r_px_size  <= pwdata[PX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:    prdata = 32'(r_width);
            REG_HEIGHT:   prdata = 32'(r_height);
            REG_OBLIQUE:  prdata = 32'(r_oblique);
            REG_EMBOLDEN: prdata = 32'(r_embolden);
            REG_PX_SIZE:  prdata = 32'(r_px_size);
            default:      prdata = '0;
        endcase
    end

    assign w_sat  = (r_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_width;
    assign h_sat  = (r_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_height;
    assign px_sat = (r_px_size > PX_W'(MAX_PIXEL_SIZE)) ? PX_W'(MAX_PIXEL_SIZE) : r_px_size;

    gsoe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_coverage   (i_coverage),
        .i_width      (w_sat),
        .i_height     (h_sat),
        .i_oblique    (r_oblique),
        .i_q_full     (q_full),
        .o_item_valid (f_valid),
        .o_item       (f_item)
    );

    gsoe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    gsoe_back #(
        .MAX_PIXEL_SIZE (MAX_PIXEL_SIZE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (q_item),
        .i_q_empty       (q_empty),
        .o_q_rd          (q_rd),
        .i_width         (w_sat),
        .i_embolden      (r_embolden),
        .i_px_size       (px_sat),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_out_row       (o_out_row),
        .o_out_column    (o_out_column),
        .o_out_value     (o_out_value),
        .o_out_row_width (o_out_row_width),
        .o_run_last      (o_run_last),
        .o_glyph_done    (o_glyph_done)
    );

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_glyph_done) |-> o_run_last)
        else $error("glyph_done without run_last");

    // a waiting result stays put until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_column) && $stable(o_out_value)))
        else $error("waiting result changed");

    // tail results of one transaction come out back to back
    a_tail_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_run_last && pop) |=> !empty)
        else $error("gap inside a row tail");

endmodule
